/* hdl/key_matrix_layer_mapper_top_assert.svh */
// Assertion macros for the key matrix layer mapper.
`ifndef KEY_MATRIX_LAYER_MAPPER_TOP_ASSERT_SVH
`define KEY_MATRIX_LAYER_MAPPER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define KMLM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define KMLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KMLM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define KMLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

/* hdl/kmlm_pkg.sv */
// Shared constants, types and codes of the key matrix layer mapper.
package kmlm_pkg;

  localparam int ROWS   = 8;
  localparam int COLS   = 8;
  localparam int LAYERS = 4;
  localparam int NKEYS  = ROWS * COLS;

  localparam int POS_W     = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int LAYER_W   = 2;
  localparam int CODE_W    = 8;
  localparam int ROW_W     = 3;
  localparam int COL_W     = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [LAYER_W-1:0] layer_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [QCNT_W-1:0]  qcnt_t;

  localparam layer_t LAYER_MAX    = layer_t'(LAYERS - 1);
  localparam layer_t LAYER_RESET  = layer_t'((LAYERS > 1) ? 1 : 0);

  localparam logic REQ_SCAN      = 1'b0;
  localparam logic REQ_MAP_WRITE = 1'b1;
  localparam logic EV_PRESS      = 1'b0;
  localparam logic EV_RELEASE    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_UP   = 2'd0,
    CFG_LAYER_DOWN = 2'd1,
    CFG_BASE_LAYER = 2'd2
  } cfg_reg_t;

  // Classified scan sample with the keymap row of that key, all layers.
  typedef struct packed {
    pos_t                    pos;
    logic                    pressed;
    logic [LAYERS-1:0][CODE_W-1:0] codes;
  } scan_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic   pop;
    logic   emit;
    layer_t layer;
  } back_stat_t;

endpackage

/* hdl/key_matrix_layer_mapper_top.sv */
// Top level of the key matrix layer mapper.
`include "key_matrix_layer_mapper_top_assert.svh"

// Layered key matrix mapper. Each input transfer is either a scan sample of
// one key (row, col, pressed) or a keymap write (map_layer, map_code). A key
// that goes from up to down yields a press event, down to up a release event;
// other samples, keymap writes and out-of-range positions yield nothing.
// Layer-up/down keycodes step the active layer on press (saturating), and
// releasing one returns to base_layer. The block takes one item per clock
// unless in_stall is high: the front end reads the whole keymap row of a key
// (all layers) from a single-port memory in the accept cycle, a two-entry
// queue decouples it from the back end, which resolves key state and layer
// for each sample. An event passes the front-end register, the queue and
// the back end's output register. The keymap has no reset; keys must be
// mapped before they are used.
// The config port is always ready; write it only while the block is idle.
module key_matrix_layer_mapper_top (
  input  logic       clk,
  input  logic       rst,
  // item input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [2:0] row,
  input  logic [2:0] col,
  input  logic       pressed,
  input  logic [1:0] map_layer,
  input  logic [7:0] map_code,
  // event output
  output logic       out_valid,
  input  logic       out_stall,
  output logic       event_kind,
  output logic [7:0] key_code,
  output logic [1:0] layer_now,
  // register writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import kmlm_pkg::*;

  // Config registers
  code_t  layer_up_code;
  code_t  layer_down_code;
  layer_t base_layer;

  // Front to queue
  logic   push_valid;
  scan_t  push_data;
  logic   q_full;

  // Queue to back
  logic   q_valid;
  scan_t  q_data;
  logic   q_pop;
  qcnt_t  q_count;

  back_stat_t stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_up_code   <= 8'd240;
      layer_down_code <= 8'd241;
      base_layer      <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LAYER_UP:   layer_up_code   <= cfg_data;
        CFG_LAYER_DOWN: layer_down_code <= cfg_data;
        CFG_BASE_LAYER: base_layer      <= cfg_data[LAYER_W-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  kmlm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .row        (row),
    .col        (col),
    .pressed    (pressed),
    .map_layer  (map_layer),
    .map_code   (map_code),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  kmlm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop        (q_pop),
    .count      (q_count)
  );

  kmlm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .layer_up_code   (layer_up_code),
    .layer_down_code (layer_down_code),
    .base_layer      (base_layer),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_kind      (event_kind),
    .key_code        (key_code),
    .layer_now       (layer_now),
    .stat            (stat)
  );

  // Queue never overfills.
  `KMLM_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, int'(q_count) <= QDEPTH, "queue overflow")
  // A sample that changes key state shows up on the output next cycle with the new layer.
  `KMLM_ASSERT_NEXT(a_event_out, clk, rst, stat.pop && stat.emit,
                    out_valid && layer_now == stat.layer, "event lost or layer mismatch")
  // Active layer stays within the layer range.
  `KMLM_ASSERT_NOW(a_layer_range, clk, rst, 1'b1, int'(stat.layer) < LAYERS, "active layer out of range")

endmodule

/* hdl/kmlm_front.sv */
// Front end: accepts items, does keymap writes, reads keymap rows for scan samples.
module kmlm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [2:0]             row,
  input  logic [2:0]             col,
  input  logic                   pressed,
  input  logic [1:0]             map_layer,
  input  logic [7:0]             map_code,
  output logic                   push_valid,
  output kmlm_pkg::scan_t        push_data,
  input  logic                   q_full
);
  import kmlm_pkg::*;

  // One row per key position, one byte lane per layer.
  logic [LAYERS-1:0][CODE_W-1:0] mem [NKEYS];
  logic [LAYERS-1:0][CODE_W-1:0] rd_codes;

  logic   s_valid;
  pos_t   s_pos;
  logic   s_pressed;

  logic   accept;
  logic   in_range;
  logic   is_scan;
  logic   is_write;
  pos_t   pos;

  assign in_range = (int'(row) < ROWS) && (int'(col) < COLS);
  assign pos      = POS_W'(int'(row) * COLS + int'(col));
  assign is_scan  = (req_type == REQ_SCAN) && in_range;
  assign is_write = (req_type == REQ_MAP_WRITE) && in_range && (int'(map_layer) < LAYERS);

  assign in_stall = s_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept && is_write) begin
      mem[pos][map_layer] <= map_code;
    end
    if (accept && is_scan) begin
      rd_codes <= mem[pos];
      s_pos     <= pos;
      s_pressed <= pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= is_scan;
    end else if (s_valid && !q_full) begin
      s_valid <= 1'b0;
    end
  end

  assign push_valid        = s_valid;
  assign push_data.pos     = s_pos;
  assign push_data.pressed = s_pressed;
  assign push_data.codes   = rd_codes;

endmodule

/* hdl/kmlm_queue.sv */
// Short FIFO of classified scan samples between front and back end.
module kmlm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  kmlm_pkg::scan_t  push_data,
  output logic             full,
  output logic             pop_valid,
  output kmlm_pkg::scan_t  pop_data,
  input  logic             pop,
  output kmlm_pkg::qcnt_t  count
);
  import kmlm_pkg::*;

  scan_t               entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic                do_push;
  logic                do_pop;

  assign full      = (int'(count) == QDEPTH);
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (int'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (int'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/kmlm_back.sv */
// Back end: key state, layer tracking and the registered event output.
module kmlm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  kmlm_pkg::scan_t       q_data,
  output logic                  q_pop,
  input  logic [7:0]            layer_up_code,
  input  logic [7:0]            layer_down_code,
  input  logic [1:0]            base_layer,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  event_kind,
  output logic [7:0]            key_code,
  output logic [1:0]            layer_now,
  output kmlm_pkg::back_stat_t  stat
);
  import kmlm_pkg::*;

  logic [NKEYS-1:0] key_down;
  layer_t           active_layer;

  logic   take;
  logic   was_down;
  logic   is_press;
  logic   is_release;
  logic   emit;
  layer_t base;
  layer_t p1, p2, r1, r2, new_layer;
  code_t  c0, cp1, cr1;

  assign take     = !out_valid || !out_stall;
  assign q_pop    = q_valid && take;
  assign was_down = key_down[q_data.pos];

  assign is_press   = q_data.pressed && !was_down;
  assign is_release = !q_data.pressed && was_down;
  assign emit       = is_press || is_release;

  assign base = (int'(base_layer) >= LAYERS) ? LAYER_MAX : base_layer;

  // Press: raise (saturating) on the current layer's code, then lower on the new one's.
  assign c0  = q_data.codes[active_layer];
  assign p1  = (c0 == layer_up_code && active_layer < LAYER_MAX) ?
               active_layer + 1'b1 : active_layer;
  assign cp1 = q_data.codes[p1];
  assign p2  = (cp1 == layer_down_code && p1 != '0) ? p1 - 1'b1 : p1;

  // Release: either layer key returns to the base layer.
  assign r1  = (c0 == layer_up_code) ? base : active_layer;
  assign cr1 = q_data.codes[r1];
  assign r2  = (cr1 == layer_down_code) ? base : r1;

  assign new_layer = is_press ? p2 : r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_down     <= '0;
      active_layer <= LAYER_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop && emit) begin
        key_down[q_data.pos] <= q_data.pressed;
        active_layer         <= new_layer;
        out_valid            <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      event_kind <= is_press ? EV_PRESS : EV_RELEASE;
      key_code   <= q_data.codes[new_layer];
      layer_now  <= new_layer;
    end
  end

  assign stat.pop   = q_pop;
  assign stat.emit  = emit;
  assign stat.layer = active_layer;

endmodule
